### hdl/lru_key_value_cache_assert.svh
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset
`define LKVC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lkvc_pkg.sv
package lkvc_pkg;

    localparam int KeyW = 32;
    localparam int ValW = 32;
    localparam int CapW = 5;

    // Operation codes
    localparam logic CmdGet = 1'b0;
    localparam logic CmdSet = 1'b1;

    typedef struct packed {
        logic                   cmd;
        logic signed [KeyW-1:0] key;
        logic signed [ValW-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic                   found;
        logic signed [ValW-1:0] read_data;
        logic                   evicted;
        logic signed [KeyW-1:0] evicted_key;
    } t_out_item;

    // One cache entry as held by a cell
    typedef struct packed {
        logic            valid;
        logic [KeyW-1:0] key;
        logic [ValW-1:0] value;
    } t_entry;

    // Per-cell control from the top level
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctl;

endpackage

### hdl/lkvc_cell.sv
module lkvc_cell
    import lkvc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cell_ctl       i_ctl,
    input  t_entry          i_prev,
    input  logic [KeyW-1:0] i_key,
    output t_entry          o_entry,
    output logic            o_hit
);

    logic            r_valid;
    logic [KeyW-1:0] r_key;
    logic [ValW-1:0] r_value;

    // Valid bit: cleared on reset or capacity write, else follows the neighbour on shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_prev.valid;
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key   <= i_prev.key;
            r_value <= i_prev.value;
        end
    end

    // Key match
    assign o_hit   = r_valid && (r_key == i_key);
    assign o_entry = '{valid: r_valid, key: r_key, value: r_value};

endmodule

### hdl/lru_key_value_cache.sv
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_ready    | i_in  (t_in_item: cmd, key, value)
// out     | output    | o_out_valid / i_out_ready  | o_out (t_out_item)
// cfg     | input     | i_cfg_we                   | i_cfg_wdata (capacity)
//
// Each item is first registered; then the key compare across all cells, the recency
// shift and the result load happen together. Input stays not-ready meanwhile.
// Cells are ordered by recency: cell 0 most recent; a shift moves entries one cell on.
// Stall: the update waits while an earlier result sits untaken in the output register.
// Synchronous reset empties every cell and sets capacity to min(16, ENTRIES).
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in_item        i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out_item       o_out,
    input  logic            i_cfg_we,
    input  logic [CapW-1:0] i_cfg_wdata
);

    localparam int CW       = $clog2(ENTRIES + 1);
    localparam int CapReset = (ENTRIES < 16) ? ENTRIES : 16;

    logic            r_busy;
    t_in_item        r_req;
    logic            r_out_valid;
    t_out_item       r_out;
    logic [CW-1:0]   r_cap;
    logic [CW-1:0]   n_cap;

    t_entry          w_entry [ENTRIES];
    logic [ENTRIES-1:0] w_hit;
    logic [ENTRIES-1:0] w_hit_above;
    logic [ENTRIES-1:0] w_lim;
    logic [ENTRIES-1:0] w_last;
    logic [ENTRIES-1:0] w_valid;
    logic            w_done;
    logic            w_found;
    logic            w_full;
    logic [ValW-1:0] w_hit_value;
    logic [KeyW-1:0] w_last_key;
    t_entry          w_head;

    assign o_in_ready  = !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_done      = r_busy && (!r_out_valid || i_out_ready);

    // Capacity clamp to 1..ENTRIES
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_cap = CW'(1);
        end else if (32'(i_cfg_wdata) > ENTRIES) begin
            n_cap = CW'(ENTRIES);
        end else begin
            n_cap = CW'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CW'(CapReset);
        end else if (i_cfg_we) begin
            r_cap <= n_cap;
        end
    end

    // Item control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && !r_busy) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !r_busy) begin
            r_req <= i_in;
        end
    end

    // Value of the hit entry, key of the last cell in use, valid bits of the row
    always_comb begin
        w_hit_value = '0;
        w_last_key  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_hit_value = w_hit_value | (w_entry[i].value & {ValW{w_hit[i]}});
            w_last_key  = w_last_key  | (w_entry[i].key   & {KeyW{w_last[i]}});
            w_valid[i]  = w_entry[i].valid;
        end
    end

    assign w_found = |w_hit;
    assign w_full  = |(w_last & w_valid);

    // New head entry: the requested key, new value on set, old value on get hit
    always_comb begin
        w_head.valid = 1'b1;
        w_head.key   = r_req.key;
        w_head.value = (r_req.cmd == CmdSet) ? r_req.value : w_hit_value;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out.found       <= w_found;
            r_out.read_data   <= (r_req.cmd == CmdSet) ? '0 :
                                 (w_found ? w_hit_value : '1);
            r_out.evicted     <= (r_req.cmd == CmdSet) && !w_found && w_full;
            r_out.evicted_key <= ((r_req.cmd == CmdSet) && !w_found && w_full) ?
                                 w_last_key : '0;
        end
    end

    // Cell row
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        localparam logic [CW-1:0] Idx = CW'(g);
        t_cell_ctl w_ctl;
        t_entry    w_prev;

        assign w_lim[g]       = Idx < r_cap;
        assign w_hit_above[g] = |(w_hit >> g);

        if (g == ENTRIES - 1) begin : g_tail
            assign w_last[g] = w_lim[g];
        end else begin : g_mid
            assign w_last[g] = w_lim[g] && !w_lim[g+1];
        end

        if (g == 0) begin : g_head
            assign w_prev = w_head;
        end else begin : g_link
            assign w_prev = w_entry[g-1];
        end

        // Hit: cells up to the hit move on; set miss: all cells within capacity move on; get miss: none
        always_comb begin
            w_ctl.clear = i_cfg_we;
            if (w_found) begin
                w_ctl.shift = w_done && w_hit_above[g];
            end else begin
                w_ctl.shift = w_done && (r_req.cmd == CmdSet) && w_lim[g];
            end
        end

        lkvc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_prev  (w_prev),
            .i_key   (r_req.key),
            .o_entry (w_entry[g]),
            .o_hit   (w_hit[g])
        );
    end

endmodule

### hdl/lkvc_checker.sv
`include "lru_key_value_cache_assert.svh"

module lkvc_checker
    import lkvc_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input t_out_item       o_out
);

    // Eviction only happens for a key that was not present
    `LKVC_ASSERT_NOW(a_evict_not_found, o_out_valid && o_out.evicted, !o_out.found,
        "eviction reported on a hit")

    // No eviction means a zero evicted key
    `LKVC_ASSERT_NOW(a_evict_key_zero, o_out_valid && !o_out.evicted, o_out.evicted_key == '0,
        "evicted key set without eviction")

    // One item in work at a time
    `LKVC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready,
        "item taken while previous item in work")

    // A stalled result holds
    `LKVC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out),
        "result changed while stalled")

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);
